/* rtl/core/gb_pkg.sv */
// Shared types, register codes and constants of the glyph blitter.
// No dependencies; every other glyph blitter file imports this package.
`default_nettype none

package gb_pkg;

   // Store geometry
   localparam int GLYPH_SLOTS     = 256;
   localparam int MAX_GLYPH_ROWS  = 8;
   localparam int MAX_GLYPH_WIDTH = 8;
   localparam int COORD_BITS      = 12;
   localparam int ROW_BITS        = $clog2(MAX_GLYPH_ROWS);
   localparam int COL_BITS        = $clog2(MAX_GLYPH_WIDTH);
   localparam int SLOT_BITS       = $clog2(GLYPH_SLOTS);
   localparam int STORE_ADDR_BITS = SLOT_BITS + ROW_BITS;
   localparam int OFFSET_BITS     = 24;
   localparam int COLOR_BITS      = 32;

   // Request kinds
   localparam logic REQ_DRAW = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   // Fallback character when a code has no glyph
   localparam logic [7:0] CHAR_FALLBACK = 8'h3F;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
   localparam logic [2:0] REG_LINE_PITCH    = 3'd2;
   localparam logic [2:0] REG_GLYPH_ROWS    = 3'd3;
   localparam logic [2:0] REG_GLYPH_COLS    = 3'd4;
   localparam logic [2:0] REG_FIRST_CODE    = 3'd5;
   localparam logic [2:0] REG_CODE_COUNT    = 3'd6;
   localparam logic [2:0] REG_LSB_FIRST     = 3'd7;

   // Offset unit operations
   localparam logic [2:0] OFS_HOLD = 3'd0;
   localparam logic [2:0] OFS_MUL  = 3'd1;
   localparam logic [2:0] OFS_BASE = 3'd2;
   localparam logic [2:0] OFS_COL  = 3'd3;
   localparam logic [2:0] OFS_ROW  = 3'd4;

   typedef struct packed {
      logic [COORD_BITS-1:0] screen_width;
      logic [COORD_BITS-1:0] screen_height;
      logic [COORD_BITS-1:0] line_pitch;
      logic [3:0]            glyph_rows;
      logic [3:0]            glyph_cols;
      logic [7:0]            first_code;
      logic [8:0]            code_count;
      logic                  lsb_first;
   } cfg_type;

   typedef struct packed {
      logic [2:0]            code;
      logic [COORD_BITS-1:0] dy;
      logic [COORD_BITS-1:0] dx;
      logic [COL_BITS-1:0]   span;
   } ofs_op_type;

endpackage

`default_nettype wire

/* rtl/core/glyph_blitter_top.sv */
// Glyph blitter top level: APB-style configuration port, request channel
// and pixel-write channel. Depends on gb_pkg and all gb_* modules.
//
// A load request writes one glyph row byte and leaves the request channel
// ready. A draw request clips the glyph to the framebuffer in the bound
// state, passes through the offset unit in the multiply and base states (one
// 12x12 multiply for the first visible row, one add for the first column),
// then emits one pixel write per cycle while the pixel-write channel does not
// stall, with a fetch state before each visible row while the glyph store
// read port returns that row. A draw with nothing visible goes from the
// bound state straight back to idle. The block accepts the next request
// while the last pixel write still waits in the output register.
`default_nettype none

module glyph_blitter_top
   import gb_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [4:0]             csr_paddr,
   input  wire logic [31:0]            csr_pwdata,
   output logic      [31:0]            csr_prdata,
   output logic                        csr_pready,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_type,
   input  wire logic [7:0]             req_char_code,
   input  wire logic signed [12:0]     req_pos_x,
   input  wire logic signed [12:0]     req_pos_y,
   input  wire logic [COLOR_BITS-1:0]  req_fg_color,
   input  wire logic [COLOR_BITS-1:0]  req_bg_color,
   input  wire logic [ROW_BITS-1:0]    req_load_row,
   input  wire logic [7:0]             req_load_bits,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [OFFSET_BITS-1:0]      rsp_pixel_offset,
   output logic [COLOR_BITS-1:0]       rsp_pixel_color,
   output logic                        rsp_last_pixel
);

   cfg_type                    cfg;
   ofs_op_type                 ofs_op;
   logic [OFFSET_BITS-1:0]     ofs_offset;
   logic [STORE_ADDR_BITS-1:0] rd_addr;
   logic [7:0]                 rd_data;
   logic                       load_wr;

   // Store a glyph row on an accepted load request
   assign load_wr = req_valid && req_ready && (req_type == REQ_LOAD);

   gb_csr_regs u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gb_glyph_ram u_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr ({req_char_code, req_load_row}),
      .wr_data (req_load_bits),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gb_offset_unit u_ofs (
      .clock  (clock),
      .op     (ofs_op),
      .pitch  (cfg.line_pitch),
      .offset (ofs_offset)
   );

   gb_draw_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_char_code    (req_char_code),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_fg_color     (req_fg_color),
      .req_bg_color     (req_bg_color),
      .ofs_op           (ofs_op),
      .ofs_offset       (ofs_offset),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_offset (rsp_pixel_offset),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   // A draw request keeps the block busy in the next cycle
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_DRAW |=> !req_ready)
      else $error("draw request did not occupy the sequencer");

   // A load request leaves the block ready
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_LOAD |=> req_ready)
      else $error("load request stalled the request channel");

   // No new request while a character still has pixels to come
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_pixel |-> !req_ready)
      else $error("request accepted before the last pixel of a character");

endmodule

`default_nettype wire

/* rtl/core/gb_csr_regs.sv */
// Configuration registers of the glyph blitter behind an APB-style port.
// Depends on gb_pkg for the register codes and the configuration struct.
`default_nettype none

module gb_csr_regs
   import gb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode a write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_pwdata[COORD_BITS-1:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[COORD_BITS-1:0];
            REG_LINE_PITCH:    cfg_in.line_pitch    = csr_pwdata[COORD_BITS-1:0];
            REG_GLYPH_ROWS:    cfg_in.glyph_rows    = csr_pwdata[3:0];
            REG_GLYPH_COLS:    cfg_in.glyph_cols    = csr_pwdata[3:0];
            REG_FIRST_CODE:    cfg_in.first_code    = csr_pwdata[7:0];
            REG_CODE_COUNT:    cfg_in.code_count    = csr_pwdata[8:0];
            REG_LSB_FIRST:     cfg_in.lsb_first     = csr_pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Return the addressed register
   always_comb begin
      unique case (reg_idx)
         REG_SCREEN_WIDTH:  csr_prdata = 32'(cfg_ff.screen_width);
         REG_SCREEN_HEIGHT: csr_prdata = 32'(cfg_ff.screen_height);
         REG_LINE_PITCH:    csr_prdata = 32'(cfg_ff.line_pitch);
         REG_GLYPH_ROWS:    csr_prdata = 32'(cfg_ff.glyph_rows);
         REG_GLYPH_COLS:    csr_prdata = 32'(cfg_ff.glyph_cols);
         REG_FIRST_CODE:    csr_prdata = 32'(cfg_ff.first_code);
         REG_CODE_COUNT:    csr_prdata = 32'(cfg_ff.code_count);
         REG_LSB_FIRST:     csr_prdata = 32'(cfg_ff.lsb_first);
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= '0;
         cfg_ff.screen_height <= '0;
         cfg_ff.line_pitch    <= '0;
         cfg_ff.glyph_rows    <= 4'd8;
         cfg_ff.glyph_cols    <= 4'd8;
         cfg_ff.first_code    <= 8'd32;
         cfg_ff.code_count    <= 9'd96;
         cfg_ff.lsb_first     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/gb_glyph_ram.sv */
// Glyph store: one byte per glyph row, one write and one registered read port.
// Depends on gb_pkg for the store geometry.
`default_nettype none

module gb_glyph_ram
   import gb_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [STORE_ADDR_BITS-1:0] wr_addr,
   input  wire logic [7:0]                 wr_data,
   input  wire logic [STORE_ADDR_BITS-1:0] rd_addr,
   output logic      [7:0]                 rd_data
);

   logic [7:0] glyph_mem_ff [GLYPH_SLOTS*MAX_GLYPH_ROWS];
   logic [7:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   // Write one row byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         glyph_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read row
   always_ff @(posedge clock) begin
      rd_data_ff <= glyph_mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/core/gb_offset_unit.sv */
// Shared offset unit: one multiply for the first pixel row, then one adder
// stepping the framebuffer offset pixel by pixel. Depends on gb_pkg.
`default_nettype none

module gb_offset_unit
   import gb_pkg::*;
(
   input  wire logic                  clock,
   input  wire ofs_op_type            op,
   input  wire logic [COORD_BITS-1:0] pitch,
   output logic      [OFFSET_BITS-1:0] offset
);

   logic [OFFSET_BITS-1:0] prod_ff;
   logic [OFFSET_BITS-1:0] prod_in;
   logic [OFFSET_BITS-1:0] off_ff;
   logic [OFFSET_BITS-1:0] off_in;
   logic [OFFSET_BITS-1:0] add_a;
   logic [OFFSET_BITS-1:0] add_b;

   assign offset = off_ff;

   // Row start of the first visible row
   assign prod_in = (op.code == OFS_MUL)
                  ? OFFSET_BITS'(op.dy) * OFFSET_BITS'(pitch) : prod_ff;

   // Select the adder operands
   always_comb begin
      unique case (op.code)
         OFS_BASE: begin
            add_a = prod_ff;
            add_b = OFFSET_BITS'(op.dx);
         end
         OFS_COL: begin
            add_a = off_ff;
            add_b = OFFSET_BITS'(1);
         end
         OFS_ROW: begin
            add_a = off_ff;
            add_b = OFFSET_BITS'(pitch) - OFFSET_BITS'(op.span);
         end
         default: begin
            add_a = off_ff;
            add_b = '0;
         end
      endcase
   end

   assign off_in = add_a + add_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      off_ff  <= off_in;
   end

endmodule

`default_nettype wire

/* rtl/core/gb_draw_seq.sv */
// Draw sequencer: glyph lookup, clipping, row/column walk and the result
// register. Depends on gb_pkg; drives gb_offset_unit and the glyph store.
`default_nettype none

module gb_draw_seq
   import gb_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire cfg_type                     cfg,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_type,
   input  wire logic [7:0]                  req_char_code,
   input  wire logic signed [12:0]          req_pos_x,
   input  wire logic signed [12:0]          req_pos_y,
   input  wire logic [COLOR_BITS-1:0]       req_fg_color,
   input  wire logic [COLOR_BITS-1:0]       req_bg_color,
   output ofs_op_type                       ofs_op,
   input  wire logic [OFFSET_BITS-1:0]      ofs_offset,
   output logic [STORE_ADDR_BITS-1:0]       rd_addr,
   input  wire logic [7:0]                  rd_data,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [OFFSET_BITS-1:0]           rsp_pixel_offset,
   output logic [COLOR_BITS-1:0]            rsp_pixel_color,
   output logic                             rsp_last_pixel
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BOUND = 3'd1;
   localparam logic [2:0] ST_MULT  = 3'd2;
   localparam logic [2:0] ST_BASE  = 3'd3;
   localparam logic [2:0] ST_FETCH = 3'd4;
   localparam logic [2:0] ST_RUN   = 3'd5;

   typedef struct packed {
      logic       ok;
      logic [2:0] lo;
      logic [2:0] last;
   } bound_type;

   // Visible span of glyph positions along one axis
   function automatic bound_type axis_bound(input logic signed [12:0] pos,
                                            input logic [COORD_BITS-1:0] extent,
                                            input logic [3:0] size,
                                            input logic [3:0] size_max);
      logic signed [14:0] pos_w;
      logic signed [14:0] lim;
      logic signed [14:0] sz;
      logic signed [14:0] lo;
      logic signed [14:0] hi;
      logic signed [14:0] hi_m1;
      logic [3:0]         sz_c;
      bound_type          b;
      pos_w  = {{2{pos[12]}}, pos};
      lim    = $signed(15'(extent)) - pos_w;
      sz_c   = (size > size_max) ? size_max : size;
      sz     = $signed(15'(sz_c));
      hi     = (lim < sz) ? lim : sz;
      lo     = pos_w[14] ? -pos_w : 15'sd0;
      hi_m1  = hi - 15'sd1;
      b.ok   = (lo < hi);
      b.lo   = lo[2:0];
      b.last = hi_m1[2:0];
      return b;
   endfunction

   logic [2:0]              state_ff, state_in;
   logic [7:0]              code_ff, code_in;
   logic signed [12:0]      px_ff, px_in;
   logic signed [12:0]      py_ff, py_in;
   logic [COLOR_BITS-1:0]   fg_ff, fg_in;
   logic [COLOR_BITS-1:0]   bg_ff, bg_in;
   logic [SLOT_BITS-1:0]    gi_ff, gi_in;
   logic [ROW_BITS-1:0]     r_ff, r_in;
   logic [ROW_BITS-1:0]     r_last_ff, r_last_in;
   logic [COL_BITS-1:0]     c_ff, c_in;
   logic [COL_BITS-1:0]     c_lo_ff, c_lo_in;
   logic [COL_BITS-1:0]     c_last_ff, c_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_BITS-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [COLOR_BITS-1:0]   rsp_color_ff, rsp_color_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [9:0]              code_end;
   logic                    hit_code;
   logic                    hit_fallback;
   logic [7:0]              mapped;
   bound_type               row_b;
   bound_type               col_b;
   logic                    out_free;
   logic                    pix_bit;

   assign req_ready        = (state_ff == ST_IDLE);
   assign rd_addr          = {gi_ff, r_ff};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_offset = rsp_offset_ff;
   assign rsp_pixel_color  = rsp_color_ff;
   assign rsp_last_pixel   = rsp_last_ff;

   // Map the character to a glyph index, falling back to '?'
   assign code_end     = 10'(cfg.first_code) + 10'(cfg.code_count);
   assign hit_code     = (code_ff >= cfg.first_code) && (10'(code_ff) < code_end);
   assign hit_fallback = (CHAR_FALLBACK >= cfg.first_code)
                       && (10'(CHAR_FALLBACK) < code_end);
   assign mapped       = (hit_code ? code_ff : CHAR_FALLBACK) - cfg.first_code;

   // Clip the glyph against the framebuffer
   assign row_b = axis_bound(py_ff, cfg.screen_height, cfg.glyph_rows,
                             4'(MAX_GLYPH_ROWS));
   assign col_b = axis_bound(px_ff, cfg.screen_width, cfg.glyph_cols,
                             4'(MAX_GLYPH_WIDTH));

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pix_bit  = cfg.lsb_first ? rd_data[c_ff] : rd_data[~c_ff];

   always_comb begin
      state_in      = state_ff;
      code_in       = code_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      fg_in         = fg_ff;
      bg_in         = bg_ff;
      gi_in         = gi_ff;
      r_in          = r_ff;
      r_last_in     = r_last_ff;
      c_in          = c_ff;
      c_lo_in       = c_lo_ff;
      c_last_in     = c_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_offset_in = rsp_offset_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;
      ofs_op.code   = OFS_HOLD;
      ofs_op.dy     = py_ff[12] ? '0 : py_ff[COORD_BITS-1:0];
      ofs_op.dx     = px_ff[12] ? '0 : px_ff[COORD_BITS-1:0];
      ofs_op.span   = c_last_ff - c_lo_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Latch a draw request; loads go straight to the store
            if (req_valid && req_type == REQ_DRAW) begin
               code_in  = req_char_code;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               fg_in    = req_fg_color;
               bg_in    = req_bg_color;
               state_in = ST_BOUND;
            end
         end
         ST_BOUND: begin
            // Drop the draw when nothing is visible or no glyph maps to the code
            if (cfg.screen_width != '0 && (hit_code || hit_fallback)
                && row_b.ok && col_b.ok) begin
               gi_in     = mapped;
               r_in      = row_b.lo;
               r_last_in = row_b.last;
               c_in      = col_b.lo;
               c_lo_in   = col_b.lo;
               c_last_in = col_b.last;
               state_in  = ST_MULT;
            end else begin
               state_in  = ST_IDLE;
            end
         end
         ST_MULT: begin
            ofs_op.code = OFS_MUL;
            state_in    = ST_BASE;
         end
         ST_BASE: begin
            ofs_op.code = OFS_BASE;
            state_in    = ST_FETCH;
         end
         ST_FETCH: begin
            // Wait for the row byte
            state_in = ST_RUN;
         end
         ST_RUN: begin
            // Emit one pixel when the output register is free and advance column or row
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = ofs_offset;
               rsp_color_in  = pix_bit ? fg_ff : bg_ff;
               rsp_last_in   = (r_ff == r_last_ff) && (c_ff == c_last_ff);
               if (c_ff == c_last_ff) begin
                  if (r_ff == r_last_ff) begin
                     state_in = ST_IDLE;
                  end else begin
                     r_in        = r_ff + 1'b1;
                     c_in        = c_lo_ff;
                     ofs_op.code = OFS_ROW;
                     state_in    = ST_FETCH;
                  end
               end else begin
                  c_in        = c_ff + 1'b1;
                  ofs_op.code = OFS_COL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      fg_ff         <= fg_in;
      bg_ff         <= bg_in;
      gi_ff         <= gi_in;
      r_ff          <= r_in;
      r_last_ff     <= r_last_in;
      c_ff          <= c_in;
      c_lo_ff       <= c_lo_in;
      c_last_ff     <= c_last_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

`default_nettype wire
